// ===== design/lrucl_pkg.sv =====
// Shared constants, codes and types of the LRU set-associative cache lookup.
package lrucl_pkg;

    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;

    localparam int ADDR_W = 32;
    localparam int CNT_W  = 32;
    localparam int APB_W  = 32;
    localparam int PADDR_W = 4;

    typedef logic [1:0] action_t;

    localparam action_t ACT_LOAD   = 2'd0;
    localparam action_t ACT_STORE  = 2'd1;
    localparam action_t ACT_MODIFY = 2'd2;

    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_SET_BITS   = 2'd0;
    localparam reg_idx_t REG_BLOCK_BITS = 2'd1;
    localparam reg_idx_t REG_WAYS_USED  = 2'd2;

    localparam logic [2:0] SET_BITS_RST   = 3'd0;
    localparam logic [4:0] BLOCK_BITS_RST = 5'd4;
    localparam logic [3:0] WAYS_USED_RST  = 4'd1;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] tag;
        logic [CNT_W-1:0]  stamp;
    } line_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == '1) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== design/lrucl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module lrucl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/lru_set_assoc_cache_lookup.sv =====
// LRU set-associative cache lookup: top level with sequencer and line RAM.
//
// Access items arrive on access_valid / access_stall with an action and a byte
// address; an item is taken at a clock edge where access_valid is high and
// access_stall is low. Each lookup gives one item on result_valid /
// result_stall; a modify gives two, and last marks the final one.
// Registers set_bits, block_bits and ways_used sit on the APB port at byte
// addresses 0, 4 and 8; the user must write them only while the block is
// idle, and the block itself does not enforce this. A lookup walks the ways
// of one set through the single line RAM, one read issued per cycle with the
// compare in the cycle after each read, and then writes the chosen line back.
// The ways in use are ways_used clamped to 1..MAX_WAYS. Only one access is
// in flight: access_stall stays high until the last result is loaded, so a
// new access is not taken until the previous one has given its last result.
// A held result does not block the lookup, but the write-back waits until
// the output register is free, so a stalled receiver holds the block.
// After reset the block sweeps all 2**MAX_SET_BITS * MAX_WAYS entries (512
// by default) of the line RAM to clear valid bits and stamps, one entry per
// cycle, with access_stall high. Totals and the stamp clock reset to zero.
module lru_set_assoc_cache_lookup #(
    parameter int MAX_SET_BITS = lrucl_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = lrucl_pkg::MAX_WAYS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lrucl_pkg::PADDR_W-1:0] paddr,
    input  logic [lrucl_pkg::APB_W-1:0]   pwdata,
    output logic [lrucl_pkg::APB_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          access_valid,
    output logic                          access_stall,
    input  logic [1:0]                    action,
    input  logic [lrucl_pkg::ADDR_W-1:0]  address,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          hit,
    output logic                          evicted,
    output logic                          last,
    output logic [lrucl_pkg::CNT_W-1:0]   hit_total,
    output logic [lrucl_pkg::CNT_W-1:0]   miss_total,
    output logic [lrucl_pkg::CNT_W-1:0]   eviction_total
);

    localparam int SETS   = 1 << MAX_SET_BITS;
    localparam int DEPTH  = SETS * MAX_WAYS;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int LINE_W = $bits(lrucl_pkg::line_t);
    localparam int AW     = lrucl_pkg::ADDR_W;
    localparam int CW     = lrucl_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SPLIT,
        S_SCAN,
        S_WRITE
    } state_t;

    // Configuration registers.
    logic [2:0] set_bits_reg;
    logic [4:0] block_bits_reg;
    logic [3:0] ways_used_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= lrucl_pkg::SET_BITS_RST;
            block_bits_reg <= lrucl_pkg::BLOCK_BITS_RST;
            ways_used_reg  <= lrucl_pkg::WAYS_USED_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                lrucl_pkg::REG_SET_BITS:   set_bits_reg   <= pwdata[2:0];
                lrucl_pkg::REG_BLOCK_BITS: block_bits_reg <= pwdata[4:0];
                lrucl_pkg::REG_WAYS_USED:  ways_used_reg  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            lrucl_pkg::REG_SET_BITS:   prdata = {29'd0, set_bits_reg};
            lrucl_pkg::REG_BLOCK_BITS: prdata = {27'd0, block_bits_reg};
            lrucl_pkg::REG_WAYS_USED:  prdata = {28'd0, ways_used_reg};
            default:                   prdata = '0;
        endcase
    end

    // Sequencer registers.
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;
    logic [1:0]       action_reg, action_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [SET_W-1:0] set_reg, set_next;
    logic [AW-1:0]    tag_reg, tag_next;
    logic [WCNT_W-1:0] rd_way_reg, rd_way_next;
    logic             pend_reg, pend_next;
    logic [WAY_W-1:0] chk_way_reg, chk_way_next;
    logic             have_empty_reg, have_empty_next;
    logic [WAY_W-1:0] empty_reg, empty_next;
    logic [WAY_W-1:0] victim_reg, victim_next;
    logic [CW-1:0]    vstamp_reg, vstamp_next;
    logic [WAY_W-1:0] target_reg, target_next;
    logic             lk_hit_reg, lk_hit_next;
    logic             evict_reg, evict_next;
    logic             second_reg, second_next;
    logic [CW-1:0]    clock_reg, clock_next;
    logic [CW-1:0]    hits_reg, hits_next;
    logic [CW-1:0]    misses_reg, misses_next;
    logic [CW-1:0]    evicts_reg, evicts_next;
    logic             res_valid_reg, res_valid_next;
    logic             hit_out_reg, hit_out_next;
    logic             evict_out_reg, evict_out_next;
    logic             last_out_reg, last_out_next;

    // Address split.
    logic [3:0]       sb;
    logic [AW-1:0]    set_mask;
    logic [AW-1:0]    set_calc;
    logic [5:0]       tag_shamt;
    logic [2*AW-1:0]  tag_wide;

    assign sb = ({1'b0, set_bits_reg} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                          : {1'b0, set_bits_reg};
    assign set_mask  = (AW'(1) << sb) - AW'(1);
    assign set_calc  = (addr_reg >> block_bits_reg) & set_mask;
    assign tag_shamt = 6'(block_bits_reg) + 6'(sb);
    assign tag_wide  = {{AW{1'b0}}, addr_reg} >> tag_shamt;

    // Ways in use, clamped to the built range.
    logic [WCNT_W-1:0] nways;

    always_comb
    begin
        if (ways_used_reg == 4'd0)
        begin
            nways = WCNT_W'(1);
        end
        else if ({28'd0, ways_used_reg} > 32'(MAX_WAYS))
        begin
            nways = WCNT_W'(MAX_WAYS);
        end
        else
        begin
            nways = WCNT_W'(ways_used_reg);
        end
    end

    // Line RAM.
    logic [IDX_W-1:0]  base;
    logic [WCNT_W-1:0] rd_sel;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [LINE_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [LINE_W-1:0] ram_rdata;
    lrucl_pkg::line_t  rd_line;
    lrucl_pkg::line_t  wr_line;

    assign base      = IDX_W'(set_reg) * IDX_W'(MAX_WAYS);
    assign rd_sel    = (rd_way_reg < nways) ? rd_way_reg : '0;
    assign ram_raddr = base + IDX_W'(rd_sel);
    assign rd_line   = lrucl_pkg::line_t'(ram_rdata);

    lrucl_ram #(
        .WIDTH (LINE_W),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // One way examined per cycle: tag compare and stamp compare.
    logic             way_match;
    logic             cur_empty;
    logic             empty_any;
    logic [WAY_W-1:0] empty_w;
    logic [WAY_W-1:0] victim_w;
    logic [CW-1:0]    vstamp_w;
    logic             last_way;
    logic             slot_free;

    assign way_match = rd_line.valid && (rd_line.tag == tag_reg);
    assign cur_empty = !rd_line.valid;
    assign empty_any = have_empty_reg || cur_empty;
    assign empty_w   = cur_empty ? chk_way_reg : empty_reg;
    assign last_way  = (WCNT_W'(chk_way_reg) == nways - WCNT_W'(1));
    assign slot_free = !res_valid_reg || !result_stall;

    always_comb
    begin
        if (chk_way_reg == '0)
        begin
            victim_w = '0;
            vstamp_w = rd_line.stamp;
        end
        else if (rd_line.stamp < vstamp_reg)
        begin
            victim_w = chk_way_reg;
            vstamp_w = rd_line.stamp;
        end
        else
        begin
            victim_w = victim_reg;
            vstamp_w = vstamp_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        action_next     = action_reg;
        addr_next       = addr_reg;
        set_next        = set_reg;
        tag_next        = tag_reg;
        rd_way_next     = rd_way_reg;
        pend_next       = pend_reg;
        chk_way_next    = chk_way_reg;
        have_empty_next = have_empty_reg;
        empty_next      = empty_reg;
        victim_next     = victim_reg;
        vstamp_next     = vstamp_reg;
        target_next     = target_reg;
        lk_hit_next     = lk_hit_reg;
        evict_next      = evict_reg;
        second_next     = second_reg;
        clock_next      = clock_reg;
        hits_next       = hits_reg;
        misses_next     = misses_reg;
        evicts_next     = evicts_reg;
        res_valid_next  = res_valid_reg && result_stall;
        hit_out_next    = hit_out_reg;
        evict_out_next  = evict_out_reg;
        last_out_next   = last_out_reg;

        wr_line.valid = 1'b1;
        wr_line.tag   = tag_reg;
        wr_line.stamp = clock_reg;
        ram_we        = 1'b0;
        ram_waddr     = base + IDX_W'(target_reg);
        ram_wdata     = LINE_W'(wr_line);

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                ram_wdata = '0;
                if (clr_idx_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + IDX_W'(1);
                end
            end
            S_IDLE:
            begin
                if (access_valid)
                begin
                    action_next = action;
                    addr_next   = address;
                    second_next = 1'b0;
                    state_next  = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                set_next        = SET_W'(set_calc);
                tag_next        = tag_wide[AW-1:0];
                rd_way_next     = '0;
                pend_next       = 1'b0;
                have_empty_next = 1'b0;
                state_next      = S_SCAN;
            end
            S_SCAN:
            begin
                // Reads run one way ahead of the compare.
                if (rd_way_reg < nways)
                begin
                    rd_way_next  = rd_way_reg + WCNT_W'(1);
                    pend_next    = 1'b1;
                    chk_way_next = WAY_W'(rd_way_reg);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (way_match)
                    begin
                        lk_hit_next = 1'b1;
                        evict_next  = 1'b0;
                        target_next = chk_way_reg;
                        state_next  = S_WRITE;
                    end
                    else
                    begin
                        have_empty_next = empty_any;
                        empty_next      = empty_w;
                        victim_next     = victim_w;
                        vstamp_next     = vstamp_w;
                        if (last_way)
                        begin
                            lk_hit_next = 1'b0;
                            evict_next  = !empty_any;
                            target_next = empty_any ? empty_w : victim_w;
                            state_next  = S_WRITE;
                        end
                    end
                end
            end
            S_WRITE:
            begin
                if (slot_free)
                begin
                    ram_we     = 1'b1;
                    clock_next = clock_reg + CW'(1);
                    if (lk_hit_reg)
                    begin
                        hits_next = lrucl_pkg::sat_inc(hits_reg);
                    end
                    else
                    begin
                        misses_next = lrucl_pkg::sat_inc(misses_reg);
                    end
                    if (evict_reg)
                    begin
                        evicts_next = lrucl_pkg::sat_inc(evicts_reg);
                    end
                    res_valid_next = 1'b1;
                    hit_out_next   = lk_hit_reg;
                    evict_out_next = evict_reg;
                    last_out_next  = second_reg || (action_reg != lrucl_pkg::ACT_MODIFY);
                    // The second lookup of a modify hits the line just written.
                    if ((action_reg == lrucl_pkg::ACT_MODIFY) && !second_reg)
                    begin
                        second_next = 1'b1;
                        lk_hit_next = 1'b1;
                        evict_next  = 1'b0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            pend_reg      <= 1'b0;
            second_reg    <= 1'b0;
            clock_reg     <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evicts_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            pend_reg      <= pend_next;
            second_reg    <= second_next;
            clock_reg     <= clock_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            evicts_reg    <= evicts_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        addr_reg       <= addr_next;
        set_reg        <= set_next;
        tag_reg        <= tag_next;
        rd_way_reg     <= rd_way_next;
        chk_way_reg    <= chk_way_next;
        have_empty_reg <= have_empty_next;
        empty_reg      <= empty_next;
        victim_reg     <= victim_next;
        vstamp_reg     <= vstamp_next;
        target_reg     <= target_next;
        lk_hit_reg     <= lk_hit_next;
        evict_reg      <= evict_next;
        hit_out_reg    <= hit_out_next;
        evict_out_reg  <= evict_out_next;
        last_out_reg   <= last_out_next;
    end

    assign access_stall   = (state_reg != S_IDLE);
    assign result_valid   = res_valid_reg;
    assign hit            = hit_out_reg;
    assign evicted        = evict_out_reg;
    assign last           = last_out_reg;
    // Totals change only when a new result is loaded, so they hold while stalled.
    assign hit_total      = hits_reg;
    assign miss_total     = misses_reg;
    assign eviction_total = evicts_reg;

endmodule

// ===== design/lrucl_checker.sv =====
// Port-level assertions for the cache lookup, bound to the top level.
module lrucl_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        access_valid,
    input logic                        access_stall,
    input logic                        result_valid,
    input logic                        result_stall,
    input logic                        hit,
    input logic                        evicted,
    input logic                        last,
    input logic [lrucl_pkg::CNT_W-1:0] hit_total,
    input logic [lrucl_pkg::CNT_W-1:0] miss_total,
    input logic [lrucl_pkg::CNT_W-1:0] eviction_total
);

    // A held result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(hit) && $stable(evicted)
            && $stable(last) && $stable(hit_total) && $stable(miss_total)
            && $stable(eviction_total))
        else $error("held result changed");

    // Only one access is in flight at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        access_valid && !access_stall |=> access_stall)
        else $error("second access taken while busy");

    // A hit never replaces a line.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(hit && evicted))
        else $error("result shows both hit and eviction");

    // Saturating totals never go down.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (hit_total >= $past(hit_total)) && (miss_total >= $past(miss_total))
            && (eviction_total >= $past(eviction_total)))
        else $error("a running total decreased");

endmodule

bind lru_set_assoc_cache_lookup lrucl_checker u_lrucl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .access_valid   (access_valid),
    .access_stall   (access_stall),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .hit            (hit),
    .evicted        (evicted),
    .last           (last),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .eviction_total (eviction_total)
);
